@@ rtl/etm_pkg.sv @@
// Shared types, constants and arithmetic helpers of the Euler transform matrix unit.
package etm_pkg;

  // Odd polynomial coefficients of the quarter-wave sine, Q30
  localparam logic [31:0] K1  = 32'd1686629713;
  localparam logic [31:0] K3  = 32'd693598669;
  localparam logic [31:0] K5  = 32'd85569306;
  localparam logic [31:0] K7  = 32'd5026995;
  localparam logic [31:0] K9  = 32'd172272;
  localparam logic [31:0] K11 = 32'd3864;

  localparam logic [32:0] ONE30  = 33'h0_4000_0000;
  localparam logic [63:0] HALF30 = 64'h0000_0000_2000_0000;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } etm_in_t;

  typedef struct packed {
    logic               matrix_kind;
    logic [1:0]         column;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic               scale_zero;
    logic               last;
  } etm_out_t;

  // scales and translations riding along the trig pipe; index 0 is x
  typedef struct packed {
    logic [2:0][23:0] scale;
    logic [2:0][31:0] shift;
  } etm_ctx_t;

  // finished model matrix and flags riding along the divider
  typedef struct packed {
    logic [8:0][31:0] model;
    logic [2:0][31:0] shift;
    logic [2:0]       szero;
  } etm_side_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic rpos;
    logic rneg;
  } etm_dflag_t;

  typedef enum logic [6:0] {
    SL_M0 = 7'b0000001,
    SL_M1 = 7'b0000010,
    SL_M2 = 7'b0000100,
    SL_MT = 7'b0001000,
    SL_N0 = 7'b0010000,
    SL_N1 = 7'b0100000,
    SL_N2 = 7'b1000000
  } etm_slot_t;

  function automatic int sh_num(input int f);
    return (2 * f >= 30) ? 2 * f - 30 : 0;
  endfunction

  function automatic int sh_den(input int f);
    return (2 * f < 30) ? 30 - 2 * f : 0;
  endfunction

  function automatic int den_w(input int f);
    return 24 + sh_den(f);
  endfunction

  function automatic int num_w(input int f);
    int na;
    int dm;
    na = 32 + sh_num(f);
    dm = den_w(f) - 1;
    return ((na > dm) ? na : dm) + 1;
  endfunction

  // Horner coefficient loaded at a given sine stage
  function automatic logic [31:0] coef(input int s);
    logic [31:0] k;
    case (s)
      2:       k = K9;
      3:       k = K7;
      4:       k = K5;
      5:       k = K3;
      default: k = K1;
    endcase
    return k;
  endfunction

  // unsigned Q30 product, round half up
  function automatic logic [32:0] qmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] t;
    t = a * b;
    t = t + HALF30;
    return t[62:30];
  endfunction

  function automatic logic [31:0] umag(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // signed Q30 product, ties away from zero; results here stay within 32 bits
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic [63:0] p;
    logic [31:0] m;
    p = umag(a) * umag(b);
    p = p + HALF30;
    m = p[61:30];
    return (a[31] ^ b[31]) ? (~m + 32'd1) : m;
  endfunction

endpackage

@@ rtl/etm_sincos.sv @@
// Six-lane pipelined fixed-point sine/cosine (Q2.30) with context pass-through.
module etm_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         angle [3],
  input  etm_pkg::etm_ctx_t   ctx_in,
  output logic                out_valid,
  output logic signed [31:0]  sc [6],
  output etm_pkg::etm_ctx_t   ctx_out
);

  localparam int AW = ANGLE_BITS;
  localparam logic [AW-1:0] QTR = {2'b01, {(AW-2){1'b0}}};

  logic [7:0]        v_r;
  logic [31:0]       x_r   [0:7][6];
  logic [1:0]        q_r   [0:7][6];
  logic [31:0]       x2_r  [0:7][6];
  logic [31:0]       p_r   [0:7][6];
  etm_pkg::etm_ctx_t ctx_r [0:7];

  logic [31:0] x0     [6];
  logic [1:0]  q0     [6];
  logic [31:0] x2_nxt [1:7][6];
  logic [31:0] p_nxt  [1:7][6];

  // lane 2k is sin, lane 2k+1 is cos of angle k
  always_comb begin
    logic [AW+15:0] ext;
    logic [AW-1:0]  a;
    logic [30:0]    xr;
    for (int l = 0; l < 6; l++) begin
      ext   = {{AW{1'b0}}, angle[l >> 1]};
      a     = ext[AW-1:0] + (((l & 1) != 0) ? QTR : '0);
      q0[l] = a[AW-1:AW-2];
      xr    = 31'(a[AW-3:0]) << (32 - AW);
      x0[l] = 32'(a[AW-2] ? (31'h4000_0000 - xr) : xr);
    end
  end

  always_comb begin
    logic [32:0] m;
    for (int s = 1; s < 8; s++) begin
      for (int l = 0; l < 6; l++) begin
        x2_nxt[s][l] = x2_r[s-1][l];
        p_nxt[s][l]  = p_r[s-1][l];
        if (s == 1) begin
          m            = etm_pkg::qmul(x_r[0][l], x_r[0][l]);
          x2_nxt[s][l] = m[31:0];
          p_nxt[s][l]  = etm_pkg::K11;
        end else if (s < 7) begin
          m           = etm_pkg::qmul(p_r[s-1][l], x2_r[s-1][l]);
          p_nxt[s][l] = etm_pkg::coef(s) - m[31:0];
        end else begin
          m = etm_pkg::qmul(x_r[s-1][l], p_r[s-1][l]);
          if (m > etm_pkg::ONE30) begin
            m = etm_pkg::ONE30;
          end
          p_nxt[s][l] = q_r[s-1][l][1] ? (~m[31:0] + 32'd1) : m[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_in;
      for (int l = 0; l < 6; l++) begin
        x_r[0][l]  <= x0[l];
        q_r[0][l]  <= q0[l];
        x2_r[0][l] <= '0;
        p_r[0][l]  <= '0;
      end
      for (int s = 1; s < 8; s++) begin
        ctx_r[s] <= ctx_r[s-1];
        for (int l = 0; l < 6; l++) begin
          x_r[s][l]  <= x_r[s-1][l];
          q_r[s][l]  <= q_r[s-1][l];
          x2_r[s][l] <= x2_nxt[s][l];
          p_r[s][l]  <= p_nxt[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      sc[l] = $signed(p_r[7][l]);
    end
  end

  assign out_valid = v_r[7];
  assign ctx_out   = ctx_r[7];

endmodule

@@ rtl/etm_rotate.sv @@
// Rotation matrix build, scaled model columns and divider operand setup.
module etm_rotate #(
  parameter  int FRAC_BITS = 16,
  localparam int NW = etm_pkg::num_w(FRAC_BITS),
  localparam int DW = etm_pkg::den_w(FRAC_BITS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  sc [6],
  input  etm_pkg::etm_ctx_t   ctx_in,
  output logic                out_valid,
  output logic [NW-1:0]       nump [9],
  output logic [DW-1:0]       den [9],
  output etm_pkg::etm_dflag_t flg [9],
  output etm_pkg::etm_side_t  side
);

  localparam int SH1 = etm_pkg::sh_num(FRAC_BITS);
  localparam int SH2 = etm_pkg::sh_den(FRAC_BITS);
  localparam int NA  = 32 + SH1;

  logic [3:0] v_r;

  // lanes: s1 c1 s2 c2 s3 c3
  // pa: c1c3 s1s2 c2s3 c1s2 c3s1 c1s3 c2c3 s1s3 c2s1 c1c2
  logic signed [31:0] pa1_r [10];
  logic signed [31:0] s2_1_r, s3_1_r;
  logic signed [31:0] pa2_r [10];
  logic signed [31:0] s2_2_r;
  logic signed [31:0] mm_r [4];
  logic signed [31:0] r_r [9];
  etm_pkg::etm_ctx_t  ctx1_r, ctx2_r, ctx3_r;

  logic [NW-1:0]       nump_r [9];
  logic [DW-1:0]       den_r [9];
  etm_pkg::etm_dflag_t flg_r [9];
  etm_pkg::etm_side_t  side_r;

  logic signed [31:0] r_nxt [9];
  logic [NW-1:0]      nump_nxt [9];
  logic [DW-1:0]      den_nxt [9];
  logic signed [31:0] model_nxt [9];

  // entries of a rotation stay near +-2^30, so the 32-bit sums cannot wrap
  always_comb begin
    r_nxt[0] = pa2_r[0] + mm_r[0];
    r_nxt[1] = pa2_r[2];
    r_nxt[2] = mm_r[1] - pa2_r[4];
    r_nxt[3] = mm_r[2] - pa2_r[5];
    r_nxt[4] = pa2_r[6];
    r_nxt[5] = mm_r[3] + pa2_r[7];
    r_nxt[6] = pa2_r[8];
    r_nxt[7] = -s2_2_r;
    r_nxt[8] = pa2_r[9];
  end

  always_comb begin
    logic signed [31:0] s;
    logic [NA-1:0]      num;
    for (int i = 0; i < 9; i++) begin
      s            = 32'($signed(ctx3_r.scale[i / 3]));
      model_nxt[i] = etm_pkg::mul30(s, r_r[i]);
      num          = NA'(etm_pkg::umag(r_r[i])) << SH1;
      den_nxt[i]   = DW'(etm_pkg::umag(s)) << SH2;
      nump_nxt[i]  = NW'(num) + NW'(den_nxt[i] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1_r[0] <= etm_pkg::mul30(sc[1], sc[5]);
      pa1_r[1] <= etm_pkg::mul30(sc[0], sc[2]);
      pa1_r[2] <= etm_pkg::mul30(sc[3], sc[4]);
      pa1_r[3] <= etm_pkg::mul30(sc[1], sc[2]);
      pa1_r[4] <= etm_pkg::mul30(sc[5], sc[0]);
      pa1_r[5] <= etm_pkg::mul30(sc[1], sc[4]);
      pa1_r[6] <= etm_pkg::mul30(sc[3], sc[5]);
      pa1_r[7] <= etm_pkg::mul30(sc[0], sc[4]);
      pa1_r[8] <= etm_pkg::mul30(sc[3], sc[0]);
      pa1_r[9] <= etm_pkg::mul30(sc[1], sc[3]);
      s2_1_r   <= sc[2];
      s3_1_r   <= sc[4];
      ctx1_r   <= ctx_in;

      pa2_r    <= pa1_r;
      s2_2_r   <= s2_1_r;
      mm_r[0]  <= etm_pkg::mul30(pa1_r[1], s3_1_r);
      mm_r[1]  <= etm_pkg::mul30(pa1_r[3], s3_1_r);
      mm_r[2]  <= etm_pkg::mul30(pa1_r[4], s2_1_r);
      mm_r[3]  <= etm_pkg::mul30(pa1_r[0], s2_1_r);
      ctx2_r   <= ctx1_r;

      r_r      <= r_nxt;
      ctx3_r   <= ctx2_r;

      for (int i = 0; i < 9; i++) begin
        nump_r[i]         <= nump_nxt[i];
        den_r[i]          <= den_nxt[i];
        flg_r[i].neg      <= r_r[i][31] ^ ctx3_r.scale[i / 3][23];
        flg_r[i].zero     <= (ctx3_r.scale[i / 3] == '0);
        flg_r[i].rpos     <= !r_r[i][31] && (r_r[i] != '0);
        flg_r[i].rneg     <= r_r[i][31];
        side_r.model[i]   <= model_nxt[i];
      end
      for (int c = 0; c < 3; c++) begin
        side_r.szero[c] <= (ctx3_r.scale[c] == '0);
      end
      side_r.shift <= ctx3_r.shift;
    end
  end

  assign out_valid = v_r[3];
  assign nump      = nump_r;
  assign den       = den_r;
  assign flg       = flg_r;
  assign side      = side_r;

endmodule

@@ rtl/etm_divider.sv @@
// Nine-lane pipelined restoring divider, one quotient bit per stage, with saturation.
module etm_divider #(
  parameter  int FRAC_BITS = 16,
  localparam int NW = etm_pkg::num_w(FRAC_BITS),
  localparam int DW = etm_pkg::den_w(FRAC_BITS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NW-1:0]       nump [9],
  input  logic [DW-1:0]       den [9],
  input  etm_pkg::etm_dflag_t flg [9],
  input  etm_pkg::etm_side_t  side_in,
  output logic                out_valid,
  output logic signed [31:0]  norm [9],
  output etm_pkg::etm_side_t  side_out
);

  localparam int WW = DW + NW;

  logic [NW+1:0]       v_r;
  // partial remainder on top, numerator shifting out / quotient shifting in below
  logic [WW-1:0]       w_r    [0:NW][9];
  logic [DW-1:0]       den_r  [0:NW][9];
  etm_pkg::etm_dflag_t flg_r  [0:NW][9];
  etm_pkg::etm_side_t  side_r [0:NW];
  logic signed [31:0]  res_r  [9];
  etm_pkg::etm_side_t  side_o_r;

  logic [WW-1:0]      w_nxt [1:NW][9];
  logic signed [31:0] res_nxt [9];

  always_comb begin
    logic [DW:0]   t;
    logic [DW:0]   dif;
    logic          ge;
    for (int s = 1; s <= NW; s++) begin
      for (int l = 0; l < 9; l++) begin
        t   = {w_r[s-1][l][WW-1:NW], w_r[s-1][l][NW-1]};
        dif = t - {1'b0, den_r[s-1][l]};
        ge  = (t >= {1'b0, den_r[s-1][l]});
        w_nxt[s][l] = {(ge ? dif[DW-1:0] : t[DW-1:0]), w_r[s-1][l][NW-2:0], ge};
      end
    end
  end

  always_comb begin
    logic [NW-1:0] q;
    logic          over_neg;
    logic          over_pos;
    for (int l = 0; l < 9; l++) begin
      q        = w_r[NW][l][NW-1:0];
      over_pos = (q[NW-1:31] != '0);
      over_neg = (q[NW-1:32] != '0) || (q[31] && (q[30:0] != '0));
      if (flg_r[NW][l].zero) begin
        res_nxt[l] = flg_r[NW][l].rpos ? etm_pkg::SAT_MAX :
                     flg_r[NW][l].rneg ? etm_pkg::SAT_MIN : '0;
      end else if (flg_r[NW][l].neg) begin
        res_nxt[l] = over_neg ? etm_pkg::SAT_MIN : (~q[31:0] + 32'd1);
      end else begin
        res_nxt[l] = over_pos ? etm_pkg::SAT_MAX : q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NW:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int l = 0; l < 9; l++) begin
        w_r[0][l]   <= {{DW{1'b0}}, nump[l]};
        den_r[0][l] <= den[l];
        flg_r[0][l] <= flg[l];
      end
      for (int s = 1; s <= NW; s++) begin
        side_r[s] <= side_r[s-1];
        for (int l = 0; l < 9; l++) begin
          w_r[s][l]   <= w_nxt[s][l];
          den_r[s][l] <= den_r[s-1][l];
          flg_r[s][l] <= flg_r[s-1][l];
        end
      end
      res_r    <= res_nxt;
      side_o_r <= side_r[NW];
    end
  end

  assign out_valid = v_r[NW+1];
  assign norm      = res_r;
  assign side_out  = side_o_r;

endmodule

@@ rtl/euler_transform_matrix_unit.sv @@
// Top level: Euler Y-X-Z transform to model and normal matrix columns.
//
// One transaction in carries three binary angles, three scales and three
// translations; seven column transactions come out, model columns 0..3 then
// normal columns 0..2, the seventh marked last. The column sequencer delivers
// one column per cycle while out_ready is high and takes a new transform only
// once its seventh column is taken; the pipeline in front of it takes a new
// transform each cycle while it has room. Data passes the sine/cosine pipe,
// rotation and model scaling, the divider (NW = 35 at FRAC_BITS 16) and the
// column buffer. A stall on the output freezes the whole pipeline in place.
module euler_transform_matrix_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  etm_pkg::etm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output etm_pkg::etm_out_t out_data
);

  localparam int NW = etm_pkg::num_w(FRAC_BITS);
  localparam int DW = etm_pkg::den_w(FRAC_BITS);

  logic                en;
  logic [15:0]         angle [3];
  etm_pkg::etm_ctx_t   ctx_in;
  logic                sc_valid;
  logic signed [31:0]  sc [6];
  etm_pkg::etm_ctx_t   sc_ctx;
  logic                rot_valid;
  logic [NW-1:0]       nump [9];
  logic [DW-1:0]       den [9];
  etm_pkg::etm_dflag_t flg [9];
  etm_pkg::etm_side_t  rot_side;
  logic                div_valid;
  logic signed [31:0]  norm [9];
  etm_pkg::etm_side_t  div_side;

  logic                hold_v_r;
  logic signed [31:0]  hold_norm_r [9];
  etm_pkg::etm_side_t  hold_side_r;
  etm_pkg::etm_slot_t  slot_r, slot_nxt;

  logic [1:0]          col;
  logic [3:0]          base;

  // whole pipeline moves when the column buffer is free or about to free up
  assign en       = !hold_v_r || (out_ready && (slot_r == etm_pkg::SL_N2));
  assign in_ready = en;

  always_comb begin
    angle[0]     = in_data.angle_y;
    angle[1]     = in_data.angle_x;
    angle[2]     = in_data.angle_z;
    ctx_in.scale[0] = in_data.scale_x;
    ctx_in.scale[1] = in_data.scale_y;
    ctx_in.scale[2] = in_data.scale_z;
    ctx_in.shift[0] = in_data.shift_x;
    ctx_in.shift[1] = in_data.shift_y;
    ctx_in.shift[2] = in_data.shift_z;
  end

  etm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .angle     (angle),
    .ctx_in    (ctx_in),
    .out_valid (sc_valid),
    .sc        (sc),
    .ctx_out   (sc_ctx)
  );

  etm_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sc_valid),
    .sc        (sc),
    .ctx_in    (sc_ctx),
    .out_valid (rot_valid),
    .nump      (nump),
    .den       (den),
    .flg       (flg),
    .side      (rot_side)
  );

  etm_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rot_valid),
    .nump      (nump),
    .den       (den),
    .flg       (flg),
    .side_in   (rot_side),
    .out_valid (div_valid),
    .norm      (norm),
    .side_out  (div_side)
  );

  always_comb begin
    slot_nxt = slot_r;
    if (en) begin
      slot_nxt = etm_pkg::SL_M0;
    end else if (out_ready) begin
      unique case (slot_r)
        etm_pkg::SL_M0: slot_nxt = etm_pkg::SL_M1;
        etm_pkg::SL_M1: slot_nxt = etm_pkg::SL_M2;
        etm_pkg::SL_M2: slot_nxt = etm_pkg::SL_MT;
        etm_pkg::SL_MT: slot_nxt = etm_pkg::SL_N0;
        etm_pkg::SL_N0: slot_nxt = etm_pkg::SL_N1;
        etm_pkg::SL_N1: slot_nxt = etm_pkg::SL_N2;
        etm_pkg::SL_N2: slot_nxt = etm_pkg::SL_M0;
        default:        slot_nxt = etm_pkg::SL_M0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      slot_r   <= etm_pkg::SL_M0;
    end else begin
      slot_r <= slot_nxt;
      if (en) begin
        hold_v_r <= div_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hold_norm_r <= norm;
      hold_side_r <= div_side;
    end
  end

  always_comb begin
    out_data.matrix_kind = 1'b0;
    out_data.scale_zero  = 1'b0;
    out_data.last        = 1'b0;
    col                  = 2'd0;
    unique case (slot_r)
      etm_pkg::SL_M0: col = 2'd0;
      etm_pkg::SL_M1: col = 2'd1;
      etm_pkg::SL_M2: col = 2'd2;
      etm_pkg::SL_MT: col = 2'd3;
      etm_pkg::SL_N0: col = 2'd0;
      etm_pkg::SL_N1: col = 2'd1;
      etm_pkg::SL_N2: col = 2'd2;
      default:        col = 2'd0;
    endcase
    base = 4'(col) * 4'd3;
    out_data.column = col;
    out_data.elem_0 = hold_side_r.model[base];
    out_data.elem_1 = hold_side_r.model[base + 4'd1];
    out_data.elem_2 = hold_side_r.model[base + 4'd2];
    if (slot_r == etm_pkg::SL_MT) begin
      out_data.elem_0 = hold_side_r.shift[0];
      out_data.elem_1 = hold_side_r.shift[1];
      out_data.elem_2 = hold_side_r.shift[2];
    end else if ((slot_r == etm_pkg::SL_N0) || (slot_r == etm_pkg::SL_N1) ||
                 (slot_r == etm_pkg::SL_N2)) begin
      out_data.matrix_kind = 1'b1;
      out_data.elem_0      = hold_norm_r[base];
      out_data.elem_1      = hold_norm_r[base + 4'd1];
      out_data.elem_2      = hold_norm_r[base + 4'd2];
      out_data.scale_zero  = hold_side_r.szero[col];
      out_data.last        = (slot_r == etm_pkg::SL_N2);
    end
  end

  assign out_valid = hold_v_r;

endmodule
